// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. The bodies are empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge once reset has been released
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/ckl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ckl_pkg;

    // Lane geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int KEY_W   = 56;
    localparam int COUNT_W = 8;
    localparam int OCC_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command kinds
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_DEPART = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] plate;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] moved_count;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

    // One lane entry as held in the RAM
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // Occupancy field keeps the low bits of the fill level
    function automatic logic [OCC_W-1:0] occ_of(input logic [FILL_W-1:0] f);
        logic [FILL_W+OCC_W-1:0] w;
        w = {{OCC_W{1'b0}}, f};
        return w[OCC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ckl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module ckl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/collapsing_keyed_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Collapsing keyed lane.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// An arrive item appends cmd.plate at the tail with a zero move count; a
// depart item removes the lowest-index entry holding cmd.plate and closes the
// gap, each entry behind it moving one place forward and counting one move.
// Result channel: done is high for exactly one cycle with result valid.
// Timing: arrive, full-lane reject and a depart on an empty lane give their
// item in the cycle after acceptance and busy stays low, so these run one per
// cycle. Any other depart keeps busy high while it walks the lane and gives
// its item in the cycle after the last busy one: one entry per cycle, set by
// the single read port of the lane RAM feeding the key comparator during the
// search and the shift that follows it.
// Reset empties the lane (fill level zero) and clears done; RAM contents are
// left as they are. The receiver cannot stall: each item is shown once and
// must be taken in that cycle.
module collapsing_keyed_lane (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ckl_pkg::cmd_t    cmd,
    output logic                  done,
    output ckl_pkg::result_t      result
);

    import ckl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_SHIFT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    result_t            result_reg, result_next;
    logic               done_reg, done_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_rdata;

    logic [FILL_W:0]    fill_ext;
    logic [FILL_W:0]    idx_p1;
    logic [FILL_W:0]    idx_p2;
    logic               key_hit;
    logic [COUNT_W-1:0] cnt_inc;
    logic [FILL_W-1:0]  fill_dec;
    logic [FILL_W-1:0]  fill_inc;

    ckl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare and count increment
    assign fill_ext = {1'b0, fill_reg};
    assign idx_p1   = (FILL_W + 1)'(idx_reg) + (FILL_W + 1)'(1);
    assign idx_p2   = (FILL_W + 1)'(idx_reg) + (FILL_W + 1)'(2);
    assign key_hit  = (ram_rdata.key == key_reg);
    assign cnt_inc  = (ram_rdata.count == COUNT_MAX) ? COUNT_MAX
                                                     : ram_rdata.count + COUNT_W'(1);
    assign fill_dec = fill_reg - FILL_W'(1);
    assign fill_inc = fill_reg + FILL_W'(1);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = '0;
        ram_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = cmd.plate;
                    if (cmd.kind == KIND_ARRIVE)
                    begin
                        done_next = 1'b1;
                        if (fill_ext == (FILL_W + 1)'(DEPTH))
                        begin
                            result_next = '{ST_FULL, '0, occ_of(fill_reg)};
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = IDX_W'(fill_reg);
                            ram_wdata   = '{cmd.plate, '0};
                            fill_next   = fill_inc;
                            result_next = '{ST_STORED, '0, occ_of(fill_inc)};
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{ST_NOT_FOUND, '0, occ_of(fill_reg)};
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            // rd data holds the entry at idx_reg
            S_SEARCH:
            begin
                if (key_hit)
                begin
                    count_next = ram_rdata.count;
                    if (idx_p1 < fill_ext)
                    begin
                        ram_raddr  = IDX_W'(idx_p1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        fill_next   = fill_dec;
                        result_next = '{ST_REMOVED, ram_rdata.count, occ_of(fill_dec)};
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (idx_p1 == fill_ext)
                begin
                    result_next = '{ST_NOT_FOUND, '0, occ_of(fill_reg)};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr = IDX_W'(idx_p1);
                    idx_next  = IDX_W'(idx_p1);
                end
            end

            // rd data holds the entry behind idx_reg; move it forward
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '{ram_rdata.key, cnt_inc};
                if (idx_p2 < fill_ext)
                begin
                    ram_raddr = IDX_W'(idx_p2);
                    idx_next  = IDX_W'(idx_p1);
                end
                else
                begin
                    fill_next   = fill_dec;
                    result_next = '{ST_REMOVED, count_reg, occ_of(fill_dec)};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `ASSERT_CLK(a_fill_bound, clk, rst_n, fill_ext <= (FILL_W + 1)'(DEPTH), "fill above depth")
    `ASSERT_CLK(a_idx_in_lane, clk, rst_n, busy |-> ((FILL_W + 1)'(idx_reg) < fill_ext), "index past tail")
    `ASSERT_CLK(a_remove_drops, clk, rst_n, (done && result.status == ST_REMOVED) |-> (fill_reg == FILL_W'($past(fill_reg) - FILL_W'(1))), "removal without fill drop")
    `ASSERT_CLK(a_count_zero, clk, rst_n, (done && result.status != ST_REMOVED) |-> (result.moved_count == '0), "count on non-removal")
    `ASSERT_CLK(a_depart_busy, clk, rst_n, (start && !busy && cmd.kind == KIND_DEPART && fill_reg != '0) |=> busy, "depart did not search")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ckl_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_ITEMS = 340;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    // Shadow of the lane, updated as each item is accepted
    logic [KEY_W-1:0]   lane_keys  [DEPTH];
    logic [COUNT_W-1:0] lane_moves [DEPTH];
    int                 lane_fill;

    result_t lane_replies [$];
    int      mismatches;
    int      stall_cycles;
    int      idle_pct;
    logic [KEY_W-1:0] plate_pool [8];

    collapsing_keyed_lane u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Work out the reply to one item and move the shadow lane on
    function automatic result_t predict_lane(input cmd_t c);
        result_t r;
        int      hit;
        r   = '0;
        hit = -1;
        if (c.kind == KIND_ARRIVE)
        begin
            if (lane_fill >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                lane_keys[lane_fill]  = c.plate;
                lane_moves[lane_fill] = '0;
                lane_fill++;
                r.status = ST_STORED;
            end
        end
        else
        begin
            for (int i = 0; i < lane_fill; i++)
            begin
                if (hit < 0 && lane_keys[i] == c.plate)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = ST_NOT_FOUND;
            end
            else
            begin
                r.status      = ST_REMOVED;
                r.moved_count = lane_moves[hit];
                // close the gap; each entry moved counts one more move
                for (int i = hit; i + 1 < lane_fill; i++)
                begin
                    lane_keys[i]  = lane_keys[i + 1];
                    lane_moves[i] = (lane_moves[i + 1] == COUNT_MAX) ? COUNT_MAX
                                                                     : lane_moves[i + 1] + 1'b1;
                end
                lane_fill--;
            end
        end
        r.occupancy = OCC_W'(lane_fill);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] rand_plate();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[KEY_W-1:0];
    endfunction

    // Up to seven characters, first one in the low byte
    function automatic logic [KEY_W-1:0] plate_of(input string s);
        logic [KEY_W-1:0] p;
        p = '0;
        for (int i = 0; i < s.len() && i < KEY_W / 8; i++)
            p[8*i +: 8] = s[i];
        return p;
    endfunction

    function automatic logic [KEY_W-1:0] ascii_plate();
        logic [KEY_W-1:0] p;
        int               len;
        p   = '0;
        len = $urandom_range(7, 1);
        for (int i = 0; i < len; i++)
            p[8*i +: 8] = 8'($urandom_range(126, 32));
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Send one item; start stays high into the next call unless idling
    task automatic send_item(input logic kind, input logic [KEY_W-1:0] plate);
        cmd_t c;
        c.kind  = kind;
        c.plate = plate;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            cmd   <= cmd_t'({1'($urandom_range(1)), rand_plate()});
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        lane_replies.push_back(predict_lane(c));
    endtask

    task automatic wait_lane_drained();
        start <= 1'b0;
        while (lane_replies.size() != 0)
            @(posedge clk);
    endtask

    // Depart on an empty lane
    task automatic test_empty_lane();
        send_item(KIND_DEPART, plate_of("ABC"));
        send_item(KIND_DEPART, '0);
    endtask

    // Fill with extreme, duplicate and near-duplicate keys, then one too many
    task automatic test_fill_and_reject();
        send_item(KIND_ARRIVE, '0);
        send_item(KIND_ARRIVE, '1);
        send_item(KIND_ARRIVE, plate_of("ABC"));
        send_item(KIND_ARRIVE, plate_of("AB") | (KEY_W'(8'h43) << 24));
        send_item(KIND_ARRIVE, plate_of("AB"));
        send_item(KIND_ARRIVE, plate_of("ABC"));
        for (int i = 0; i < DEPTH - 6; i++)
            send_item(KIND_ARRIVE, plate_of($sformatf("CAR%02d", i)));
        send_item(KIND_ARRIVE, plate_of("XYZ"));
    endtask

    // Bytes after a zero byte count; duplicates go lowest index first
    task automatic test_key_matching();
        send_item(KIND_DEPART, plate_of("AB"));
        send_item(KIND_DEPART, plate_of("ABC"));
        send_item(KIND_DEPART, plate_of("ABD"));
    endtask

    // Head, tail and all-ones departures after several moves
    task automatic test_collapse_counts();
        send_item(KIND_DEPART, '0);
        send_item(KIND_DEPART, plate_of($sformatf("CAR%02d", DEPTH - 7)));
        send_item(KIND_DEPART, '1);
    endtask

    // Mixed traffic: departs mostly aim at held keys
    task automatic test_random_traffic();
        int               phase_idle [4];
        int               arrive_pct;
        logic [KEY_W-1:0] p;
        int               pick;
        phase_idle = '{0, 55, 0, 9};
        arrive_pct = 50;
        for (int i = 0; i < 8; i++)
            plate_pool[i] = (i < 6) ? ascii_plate() : rand_plate();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // bursts that fill or empty the lane
                if (n % 24 == 0)
                    arrive_pct = ($urandom_range(2) == 0) ? 85 :
                                 ($urandom_range(1) == 0) ? 50 : 15;
                pick = $urandom_range(99);
                if ($urandom_range(99) < arrive_pct)
                begin
                    if (pick < 50)
                        p = plate_pool[$urandom_range(7)];
                    else if (pick < 70 && lane_fill > 0)
                        p = lane_keys[$urandom_range(lane_fill - 1)];
                    else
                        p = rand_plate();
                    send_item(KIND_ARRIVE, p);
                end
                else
                begin
                    if (lane_fill > 0 && pick < 65)
                        p = lane_keys[$urandom_range(lane_fill - 1)];
                    else if (lane_fill > 0 && pick < 80)
                        p = lane_keys[$urandom_range(lane_fill - 1)]
                            ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
                    else if (pick < 90)
                        p = plate_pool[$urandom_range(7)];
                    else
                        p = rand_plate();
                    send_item(KIND_DEPART, p);
                end
            end
            wait_lane_drained();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= '0;
        lane_fill  = 0;
        mismatches = 0;
        idle_pct   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lane();
        test_fill_and_reject();
        test_key_matching();
        test_collapse_counts();
        wait_lane_drained();
        test_random_traffic();

        wait_lane_drained();
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Compare each reply with the oldest one outstanding
    always @(posedge clk)
    begin : check_replies
        result_t want;
        if (rst_n && done)
        begin
            if (lane_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply with none outstanding: status %0d count %0d occ %0d",
                                          result.status, result.moved_count, result.occupancy));
            end
            else
            begin
                want = lane_replies.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want.status, result.status));
                if (result.moved_count !== want.moved_count)
                    report_mismatch($sformatf("moved_count expected %0d got %0d",
                                              want.moved_count, result.moved_count));
                if (result.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy expected %0d got %0d",
                                              want.occupancy, result.occupancy));
            end
        end
    end

    // Watchdog: too long with no item taken and no reply
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
